// ===== hw/rtl/tdp_pkg.sv =====
// Package for the trial-division prime test.
// Holds the sequencer state type and the divider control/status structs.
// No dependencies.
package tdp_pkg;

    // Sequencer states
    typedef enum logic [1:0] {
        S_IDLE,
        S_DIV,
        S_OUT
    } t_state;

    // Request from the sequencer to the shared divider
    typedef struct packed {
        logic start;
    } t_div_ctl;

    // Status from the divider back to the sequencer
    typedef struct packed {
        logic busy;
        logic done;
    } t_div_sts;

endpackage

// ===== hw/rtl/tdp_div.sv =====
// Shared restoring divider, one quotient bit per cycle.
// Gives quotient and remainder of an unsigned WIDTH-bit division.
// Depends on tdp_pkg.
module tdp_div import tdp_pkg::*; #(
    parameter int WIDTH = 32
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  t_div_ctl         i_ctl,
    input  logic [WIDTH-1:0] i_dividend,
    input  logic [WIDTH-1:0] i_divisor,
    output t_div_sts         o_sts,
    output logic [WIDTH-1:0] o_quotient,
    output logic [WIDTH-1:0] o_remainder
);

    localparam int CW = $clog2(WIDTH);

    logic [CW-1:0]    r_cnt;
    logic             r_busy;
    logic             r_done;
    logic [WIDTH-1:0] r_rem;
    logic [WIDTH-1:0] r_quo;
    logic [WIDTH-1:0] r_dvs;

    logic [WIDTH:0]   trial;
    logic [WIDTH:0]   diff;
    logic             fits;

    // One restoring step: shift in next dividend bit, subtract if it fits
    always_comb begin
        trial = {r_rem, r_quo[WIDTH-1]};
        diff  = trial - {1'b0, r_dvs};
        fits  = (trial >= {1'b0, r_dvs});
    end

    // Control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_ctl.start) begin
                r_busy <= 1'b1;
                r_cnt  <= CW'(WIDTH - 1);
            end else if (r_busy) begin
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == '0) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    // Datapath
    always_ff @(posedge i_clk) begin
        if (i_ctl.start) begin
            r_quo <= i_dividend;
            r_rem <= '0;
            r_dvs <= i_divisor;
        end else if (r_busy) begin
            r_rem <= fits ? diff[WIDTH-1:0] : trial[WIDTH-1:0];
            r_quo <= {r_quo[WIDTH-2:0], fits};
        end
    end

    assign o_sts.busy  = r_busy;
    assign o_sts.done  = r_done;
    assign o_quotient  = r_quo;
    assign o_remainder = r_rem;

endmodule

// ===== hw/rtl/trial_division_prime_test.sv =====
// Top level of the trial-division prime test.
// Sequencer around the shared divider tdp_div.
// Depends on tdp_pkg and tdp_div.
//
// Usage:
//   Input channel: i_valid / o_stall carry i_value (VALUE_WIDTH bits).
//   Output channel: o_valid / i_stall carry o_is_prime.
//   A transaction happens at a rising edge with valid high and stall low.
//   One result comes out for every input transaction, in order.
// Sequence:
//   Values 0, 1, 2 and even values: result valid in the cycle after acceptance.
//   Odd values: one division per trial divisor 3, 5, 7, ... up to the first
//   divisor above the square root or the first factor.
// Throughput:
//   One value at a time; o_stall is high from acceptance until the result
//   transaction completes. The shared divider sets the pace.
// Reset:
//   Synchronous, active low; returns to idle with no result pending.
// Back-pressure:
//   While i_stall is high the result is held stable and no new value is taken.
module trial_division_prime_test import tdp_pkg::*; #(
    parameter int VALUE_WIDTH = 32
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_valid,
    output logic                   o_stall,
    input  logic [VALUE_WIDTH-1:0] i_value,
    output logic                   o_valid,
    input  logic                   i_stall,
    output logic                   o_is_prime
);

    t_state                 r_state, n_state;
    logic [VALUE_WIDTH-1:0] r_value, n_value;
    logic [VALUE_WIDTH-1:0] r_dvs,   n_dvs;
    logic                   r_prime, n_prime;

    t_div_ctl               div_ctl;
    t_div_sts               div_sts;
    logic [VALUE_WIDTH-1:0] quo;
    logic [VALUE_WIDTH-1:0] rem;

    logic                   in_take;

    assign in_take = i_valid && (r_state == S_IDLE);

    // Shared divider: value / divisor
    tdp_div #(
        .WIDTH (VALUE_WIDTH)
    ) u_div (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_ctl       (div_ctl),
        .i_dividend  (n_value),
        .i_divisor   (n_dvs),
        .o_sts       (div_sts),
        .o_quotient  (quo),
        .o_remainder (rem)
    );

    // State register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Payload registers
    always_ff @(posedge i_clk) begin
        r_value <= n_value;
        r_dvs   <= n_dvs;
        r_prime <= n_prime;
    end

    // Next state and divider requests
    always_comb begin
        n_state       = r_state;
        n_value       = r_value;
        n_dvs         = r_dvs;
        n_prime       = r_prime;
        div_ctl.start = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                if (in_take) begin
                    n_value = i_value;
                    n_dvs   = VALUE_WIDTH'(3);
                    priority if (i_value[VALUE_WIDTH-1:1] == '0) begin
                        // zero and one
                        n_prime = 1'b0;
                        n_state = S_OUT;
                    end else if (i_value == VALUE_WIDTH'(2)) begin
                        n_prime = 1'b1;
                        n_state = S_OUT;
                    end else if (!i_value[0]) begin
                        n_prime = 1'b0;
                        n_state = S_OUT;
                    end else begin
                        div_ctl.start = 1'b1;
                        n_state       = S_DIV;
                    end
                end
            end
            S_DIV: begin
                if (div_sts.done) begin
                    priority if (r_dvs > quo) begin
                        // divisor squared exceeds value: no factor found
                        n_prime = 1'b1;
                        n_state = S_OUT;
                    end else if (rem == '0) begin
                        n_prime = 1'b0;
                        n_state = S_OUT;
                    end else begin
                        n_dvs         = r_dvs + VALUE_WIDTH'(2);
                        div_ctl.start = 1'b1;
                    end
                end
            end
            S_OUT: begin
                if (!i_stall) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    assign o_stall    = (r_state != S_IDLE);
    assign o_valid    = (r_state == S_OUT);
    assign o_is_prime = r_prime;

    // A divide finishes only while the sequencer waits for it
    a_done_in_div: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        div_sts.done |-> (r_state == S_DIV))
        else $error("divider finished outside of a trial");

    // No new divide is requested while one is running
    a_no_restart: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        div_sts.busy |-> !div_ctl.start)
        else $error("divider restarted while busy");

    // An odd value above two that enters the trial loop starts a divide at once
    a_trial_starts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_IDLE && n_state == S_DIV) |=> div_sts.busy)
        else $error("trial loop entered without a divide in flight");

    // A result that was stalled is still offered with the same value
    a_result_held: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && i_stall) |=> (o_valid && $stable(o_is_prime)))
        else $error("stalled result dropped or changed");

endmodule

// ===== test/trial_division_prime_test_tb.sv =====
// Testbench for trial_division_prime_test: directed table, then random values.
// Each verdict is checked against a typed-in verdict or an in-bench trial-division predictor.
// Depends on tdp_pkg and the trial_division_prime_test RTL.
module trial_division_prime_test_tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int VW = 32;
    localparam int RANDOM_VALUES = 80;
    localparam int HOLD_CYCLES = 400;
    localparam int DRAIN_CYCLES = 40;

    // One directed row; known verdict typed in where it is obvious
    typedef struct {
        logic [VW-1:0] value;
        bit            typed;
        bit            verdict;
    } t_row;

    // One pending verdict
    typedef struct {
        logic [VW-1:0] value;
        bit            verdict;
    } t_pending;

    logic          i_clk;
    logic          i_rst_n;
    logic          i_valid;
    logic          o_stall;
    logic [VW-1:0] i_value;
    logic          o_valid;
    logic          i_stall;
    logic          o_is_prime;

    t_pending pending_verdicts[$];
    int       verdicts_seen;
    int       fail_count;

    trial_division_prime_test #(.VALUE_WIDTH(VW)) uut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_valid    (i_valid),
        .o_stall    (o_stall),
        .i_value    (i_value),
        .o_valid    (o_valid),
        .i_stall    (i_stall),
        .o_is_prime (o_is_prime)
    );

    // Clock
    initial i_clk = 1'b0;
    always #5 i_clk = ~i_clk;

    // Trial division over odd divisors, bound kept as d <= v / d
    function automatic bit prime_by_division(logic [VW-1:0] value);
        logic [63:0] v;
        logic [63:0] d;
        v = 64'(value);
        if (v <= 64'd1) return 1'b0;
        if (v == 64'd2) return 1'b1;
        if (v[0] == 1'b0) return 1'b0;
        for (d = 64'd3; d <= v / d; d += 64'd2) begin
            if (v % d == 64'd0) return 1'b0;
        end
        return 1'b1;
    endfunction

    // Stretch in which neither side idles
    function automatic bit calm_window();
        return (verdicts_seen >= 40) && (verdicts_seen < 65);
    endfunction

    function automatic bit idle_roll();
        return !calm_window() && ($urandom_range(0, 99) < 29);
    endfunction

    // Random values: mostly small so trial division stays short; wide values
    // are even or carry a small odd factor, which ends the search early
    function automatic logic [VW-1:0] random_value();
        int unsigned pick;
        logic [VW-1:0] r;
        logic [VW-1:0] k;
        pick = $urandom_range(0, 99);
        if (pick < 60) begin
            return VW'($urandom_range(0, 65535));
        end else if (pick < 70) begin
            return VW'($urandom_range(0, 300));
        end else if (pick < 82) begin
            r = $urandom;
            r[0] = 1'b0;
            return r;
        end else if (pick < 94) begin
            r = $urandom_range(0, 32'h5555_5554) | 32'd1;
            return r * 32'd3;
        end else begin
            k = ($urandom_range(0, 1) == 0) ? 32'd5 : 32'd7;
            r = $urandom_range(0, (32'hFFFF_FFFF / k) - 1) | 32'd1;
            return r * k;
        end
    endfunction

    // Offer one value, with random gaps, and log its verdict on acceptance
    task automatic offer_value(logic [VW-1:0] value, bit verdict);
        t_pending p;
        @(negedge i_clk);
        while (idle_roll()) begin
            i_valid <= 1'b0;
            @(negedge i_clk);
        end
        i_valid <= 1'b1;
        i_value <= value;
        do @(posedge i_clk); while (o_stall);
        p.value = value;
        p.verdict = verdict;
        pending_verdicts.push_back(p);
    endtask

    // Result check at the rising edge
    always @(posedge i_clk) begin
        if (i_rst_n && o_valid && !i_stall) begin
            if (pending_verdicts.size() == 0) begin
                $display("%0t: unexpected result transaction, is_prime=%0b",
                         $realtime, o_is_prime);
                fail_count++;
            end else begin
                t_pending p;
                p = pending_verdicts.pop_front();
                if (o_is_prime !== p.verdict) begin
                    $display("%0t: value %0d: expected is_prime=%0b, actual %0b",
                             $realtime, p.value, p.verdict, o_is_prime);
                    fail_count++;
                end
            end
            verdicts_seen++;
        end
    end

    // Receiver: random stalls, one long hold so the block backs up
    initial begin
        bit held;
        held = 1'b0;
        i_stall = 1'b0;
        forever begin
            @(negedge i_clk);
            if (!held && verdicts_seen >= 20) begin
                held = 1'b1;
                i_stall <= 1'b1;
                repeat (HOLD_CYCLES) @(negedge i_clk);
            end
            i_stall <= idle_roll();
        end
    end

    // Stimulus
    initial begin
        t_row rows[$];
        logic [VW-1:0] v;

        i_rst_n = 1'b0;
        i_valid = 1'b0;
        i_value = '0;
        verdicts_seen = 0;
        fail_count = 0;

        rows = '{
            '{32'd0,           1'b1, 1'b0},
            '{32'd1,           1'b1, 1'b0},
            '{32'd2,           1'b1, 1'b1},
            '{32'd3,           1'b1, 1'b1},
            '{32'd4,           1'b1, 1'b0},
            '{32'hFFFF_FFFE,   1'b1, 1'b0},
            '{32'h8000_0000,   1'b1, 1'b0},
            '{32'hFFFF_FFFF,   1'b0, 1'b0},
            '{32'd5,           1'b0, 1'b0},
            '{32'd9,           1'b0, 1'b0},
            '{32'd25,          1'b0, 1'b0},
            '{32'd121,         1'b0, 1'b0},
            '{32'd169,         1'b0, 1'b0},
            '{32'd10403,       1'b0, 1'b0},
            '{32'd65521,       1'b0, 1'b0},
            '{32'd65535,       1'b0, 1'b0},
            '{32'h8000_0001,   1'b0, 1'b0},
            '{32'h5555_5555,   1'b0, 1'b0},
            '{32'hAAAA_AAAA,   1'b0, 1'b0},
            '{32'd7919,        1'b0, 1'b0}
        };

        repeat (2) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // Directed table
        foreach (rows[n]) begin
            offer_value(rows[n].value,
                        rows[n].typed ? rows[n].verdict : prime_by_division(rows[n].value));
        end

        // Random part
        repeat (RANDOM_VALUES) begin
            v = random_value();
            offer_value(v, prime_by_division(v));
        end
        @(negedge i_clk);
        i_valid <= 1'b0;

        wait (pending_verdicts.size() == 0);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (fail_count == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

    // Watchdog
    initial begin
        #30ms;
        $display("Test completed with failures");
        $finish;
    end

endmodule

// ===== filelist.f =====
hw/rtl/tdp_pkg.sv
hw/rtl/tdp_div.sv
hw/rtl/trial_division_prime_test.sv
test/trial_division_prime_test_tb.sv
